// ----- src/msc_pkg.sv -----
// Shared types, constants and edge tables for the marching squares contour block.
// Depends on nothing; the top, the divider and the bench use it by scoped names.
`default_nettype none
package msc_pkg;

    localparam int MAX_COLUMN = 1024;
    localparam int ROW_W      = $clog2(MAX_COLUMN);
    localparam int LEN_W      = 11;
    localparam int WORD_W     = 32;
    localparam int DIV_W      = 33;
    localparam int MU_W       = 17;
    localparam int PROD_W     = MU_W + 1 + DIV_W;

    // configuration register indexes
    localparam logic [1:0] CFG_ISO_LEVEL     = 2'd0;
    localparam logic [1:0] CFG_COLUMN_LENGTH = 2'd1;
    localparam logic [1:0] CFG_COLOUR_ENABLE = 2'd2;

    typedef struct packed {
        logic signed [WORD_W-1:0] v;
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] y;
        logic signed [WORD_W-1:0] z;
        logic signed [WORD_W-1:0] c;
    } t_point;

    localparam int POINT_W = $bits(t_point);

    typedef enum logic [1:0] {
        EDGE_LEFT,
        EDGE_RIGHT,
        EDGE_BOTTOM,
        EDGE_TOP
    } t_edge;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_EDGE,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_EMIT
    } t_state;

    // number of crossings for a case code
    function automatic logic [2:0] edge_count(input logic [3:0] cs);
        logic [2:0] n;
        case (cs)
            4'd0, 4'd15: n = 3'd0;
            4'd6, 4'd9:  n = 3'd4;
            default:     n = 3'd2;
        endcase
        return n;
    endfunction

    // k-th crossed edge of a case, in emission order
    function automatic t_edge edge_pick(input logic [3:0] cs, input logic [1:0] k);
        t_edge e0;
        t_edge e1;
        t_edge e2;
        t_edge e3;
        t_edge r;
        e0 = EDGE_LEFT;
        e1 = EDGE_LEFT;
        e2 = EDGE_LEFT;
        e3 = EDGE_LEFT;
        case (cs)
            4'd1:  begin e0 = EDGE_LEFT;  e1 = EDGE_BOTTOM; end
            4'd2:  begin e0 = EDGE_RIGHT; e1 = EDGE_BOTTOM; end
            4'd3:  begin e0 = EDGE_LEFT;  e1 = EDGE_RIGHT;  end
            4'd4:  begin e0 = EDGE_LEFT;  e1 = EDGE_TOP;    end
            4'd5:  begin e0 = EDGE_TOP;   e1 = EDGE_BOTTOM; end
            4'd6:  begin
                e0 = EDGE_LEFT;  e1 = EDGE_TOP;
                e2 = EDGE_RIGHT; e3 = EDGE_BOTTOM;
            end
            4'd7:  begin e0 = EDGE_TOP;   e1 = EDGE_RIGHT;  end
            4'd8:  begin e0 = EDGE_TOP;   e1 = EDGE_RIGHT;  end
            4'd9:  begin
                e0 = EDGE_TOP;    e1 = EDGE_RIGHT;
                e2 = EDGE_BOTTOM; e3 = EDGE_LEFT;
            end
            4'd10: begin e0 = EDGE_TOP;   e1 = EDGE_BOTTOM; end
            4'd11: begin e0 = EDGE_TOP;   e1 = EDGE_LEFT;   end
            4'd12: begin e0 = EDGE_LEFT;  e1 = EDGE_RIGHT;  end
            4'd13: begin e0 = EDGE_RIGHT; e1 = EDGE_BOTTOM; end
            4'd14: begin e0 = EDGE_LEFT;  e1 = EDGE_BOTTOM; end
            default: begin e0 = EDGE_LEFT; end
        endcase
        case (k)
            2'd0:    r = e0;
            2'd1:    r = e1;
            2'd2:    r = e2;
            default: r = e3;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/marching_squares_contour.sv -----
// Marching squares isoline extractor: sequencer, column buffer, shared divider
// and shared multiplier. Depends on msc_pkg, msc_ram and msc_div.
//
//  channel | direction | handshake               | word
//  input   | in        | i_in_valid / o_in_stall | sample, xyz, colour, first_point
//  output  | out       | o_out_valid / i_out_stall | vertex xyz, colour, case, last
//  config  | in        | i_cfg_valid / o_cfg_ready | index, data
//
// A point is classified, then each of its 0, 2 or 4 vertices passes edge setup,
// 17 divider steps and a handoff, the shared multiplier and adder for x, y, z and
// colour, and the hand-out of the vertex word, which may wait on output stall.
// Copied endpoints skip the divider and multiplier. Synchronous active-low reset.
// Output stall holds the vertex word; input stall is high while a point is in work.
`default_nettype none
module marching_squares_contour (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_sample_value,
    input  wire logic [31:0] i_pos_x,
    input  wire logic [31:0] i_pos_y,
    input  wire logic [31:0] i_pos_z,
    input  wire logic [31:0] i_colour_value,
    input  wire logic        i_first_point,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_vert_x,
    output logic [31:0]      o_vert_y,
    output logic [31:0]      o_vert_z,
    output logic [31:0]      o_vert_colour,
    output logic [3:0]       o_cell_case,
    output logic             o_last_of_cell,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int ROW_W = msc_pkg::ROW_W;
    localparam int LEN_W = msc_pkg::LEN_W;
    localparam int DIV_W = msc_pkg::DIV_W;
    localparam int MU_W  = msc_pkg::MU_W;

    msc_pkg::t_state r_state, n_state;

    // configuration
    logic signed [31:0] r_iso;
    logic [LEN_W-1:0]   r_len;
    logic               r_col_en;

    // grid position and held corners
    logic [ROW_W-1:0]   r_row, n_row;
    logic               r_past, n_past;
    msc_pkg::t_point    r_held_a, n_held_a, r_held_b, n_held_b;

    // working point set of the cell in progress
    msc_pkg::t_point    r_cur, n_cur, r_pc, n_pc, r_wa, n_wa, r_wb, n_wb;
    msc_pkg::t_point    r_e1, n_e1, r_e2, n_e2;
    logic [3:0]         r_case, n_case;
    logic [2:0]         r_n, n_n;
    logic [1:0]         r_k, n_k;
    logic [1:0]         r_coord, n_coord;
    logic [MU_W-1:0]    r_mu, n_mu;
    logic signed [msc_pkg::PROD_W-1:0] r_prod, n_prod;
    logic [31:0]        r_ox, n_ox, r_oy, n_oy, r_oz, n_oz, r_oc, n_oc;

    logic               w_accept;
    logic               w_emit_take;
    logic [ROW_W-1:0]   w_raddr;
    logic [msc_pkg::POINT_W-1:0] w_rdata;
    msc_pkg::t_point    w_rpoint;
    msc_pkg::t_point    w_p1, w_p2;
    msc_pkg::t_edge     w_edge;
    logic [LEN_W-1:0]   w_len_eff;
    logic [ROW_W:0]     w_row_inc;
    logic [3:0]         w_case;
    logic               w_active;
    logic               w_above, w_below;
    logic signed [DIV_W-1:0] w_num, w_den;
    logic [DIV_W-1:0]   w_un, w_ud;
    logic               w_div_start, w_div_done;
    logic [MU_W-1:0]    w_quo;
    logic signed [31:0] w_q1, w_q2;
    logic signed [DIV_W-1:0] w_dq;
    logic [31:0]        w_sum;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_emit_take = (r_state == msc_pkg::ST_EMIT) && !i_out_stall;
    assign w_raddr     = i_first_point ? '0 : r_row;
    assign w_rpoint    = msc_pkg::t_point'(w_rdata);

    // previous column buffer, read on accept, written back in the classify cycle
    msc_ram #(
        .WIDTH (msc_pkg::POINT_W),
        .DEPTH (msc_pkg::MAX_COLUMN)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == msc_pkg::ST_CLASS),
        .i_waddr (r_row),
        .i_wdata (r_cur),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    msc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_un),
        .i_den   (w_ud),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // configuration writes
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso    <= '0;
            r_len    <= LEN_W'(1);
            r_col_en <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                msc_pkg::CFG_ISO_LEVEL:     r_iso    <= i_cfg_data;
                msc_pkg::CFG_COLUMN_LENGTH: r_len    <= i_cfg_data[LEN_W-1:0];
                msc_pkg::CFG_COLOUR_ENABLE: r_col_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective length clamped to 1..MAX_COLUMN
    always_comb begin
        if (r_len == '0) begin
            w_len_eff = LEN_W'(1);
        end else if (32'(r_len) > msc_pkg::MAX_COLUMN) begin
            w_len_eff = LEN_W'(msc_pkg::MAX_COLUMN);
        end else begin
            w_len_eff = r_len;
        end
    end

    // corner classes and endpoint selection
    always_comb begin
        w_case    = {r_cur.v > r_iso, w_rpoint.v > r_iso,
                     r_held_b.v > r_iso, r_held_a.v > r_iso};
        w_active  = r_past && (r_row != '0);
        w_row_inc = {1'b0, r_row} + 1'b1;
        w_edge    = msc_pkg::edge_pick(r_case, r_k);
        case (w_edge)
            msc_pkg::EDGE_LEFT:   begin w_p1 = r_wa; w_p2 = r_pc;  end
            msc_pkg::EDGE_RIGHT:  begin w_p1 = r_wb; w_p2 = r_cur; end
            msc_pkg::EDGE_BOTTOM: begin w_p1 = r_wa; w_p2 = r_wb;  end
            default:              begin w_p1 = r_pc; w_p2 = r_cur; end
        endcase
        w_above = (w_p1.v > r_iso) && (w_p2.v > r_iso);
        w_below = (w_p1.v < r_iso) && (w_p2.v < r_iso);
        w_num   = DIV_W'(r_iso) - DIV_W'(w_p1.v);
        w_den   = DIV_W'(w_p2.v) - DIV_W'(w_p1.v);
        w_un    = w_num[DIV_W-1] ? DIV_W'(-w_num) : DIV_W'(w_num);
        w_ud    = w_den[DIV_W-1] ? DIV_W'(-w_den) : DIV_W'(w_den);
    end

    // coordinate pair for the shared multiplier
    always_comb begin
        case (r_coord)
            2'd0:    begin w_q1 = r_e1.x; w_q2 = r_e2.x; end
            2'd1:    begin w_q1 = r_e1.y; w_q2 = r_e2.y; end
            2'd2:    begin w_q1 = r_e1.z; w_q2 = r_e2.z; end
            default: begin w_q1 = r_e1.c; w_q2 = r_e2.c; end
        endcase
        w_dq  = DIV_W'(w_q2) - DIV_W'(w_q1);
        w_sum = w_q1 + r_prod[47:16];
    end

    assign w_div_start = (r_state == msc_pkg::ST_EDGE) && !w_above && !w_below
                         && (w_den != '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            msc_pkg::ST_IDLE:  if (w_accept) n_state = msc_pkg::ST_CLASS;
            msc_pkg::ST_CLASS: begin
                if (w_active && msc_pkg::edge_count(w_case) != 3'd0) begin
                    n_state = msc_pkg::ST_EDGE;
                end else begin
                    n_state = msc_pkg::ST_IDLE;
                end
            end
            msc_pkg::ST_EDGE: begin
                if (w_above || w_below) begin
                    n_state = msc_pkg::ST_EMIT;
                end else if (w_den == '0) begin
                    n_state = msc_pkg::ST_MUL;
                end else begin
                    n_state = msc_pkg::ST_DIV;
                end
            end
            msc_pkg::ST_DIV:   if (w_div_done) n_state = msc_pkg::ST_MUL;
            msc_pkg::ST_MUL:   n_state = msc_pkg::ST_ADD;
            msc_pkg::ST_ADD: begin
                n_state = (r_coord == 2'd3) ? msc_pkg::ST_EMIT : msc_pkg::ST_MUL;
            end
            msc_pkg::ST_EMIT: begin
                if (w_emit_take) begin
                    n_state = (3'(r_k) + 3'd1 == r_n) ? msc_pkg::ST_IDLE
                                                      : msc_pkg::ST_EDGE;
                end
            end
            default: n_state = msc_pkg::ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_row    = r_row;
        n_past   = r_past;
        n_held_a = r_held_a;
        n_held_b = r_held_b;
        n_cur    = r_cur;
        n_pc     = r_pc;
        n_wa     = r_wa;
        n_wb     = r_wb;
        n_e1     = r_e1;
        n_e2     = r_e2;
        n_case   = r_case;
        n_n      = r_n;
        n_k      = r_k;
        n_coord  = r_coord;
        n_mu     = r_mu;
        n_prod   = r_prod;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_oz     = r_oz;
        n_oc     = r_oc;
        case (r_state)
            msc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_cur = {i_sample_value, i_pos_x, i_pos_y, i_pos_z, i_colour_value};
                    if (i_first_point) begin
                        n_row  = '0;
                        n_past = 1'b0;
                    end
                end
            end
            msc_pkg::ST_CLASS: begin
                // snapshot the cell, then advance held corners and row
                n_pc     = w_rpoint;
                n_wa     = r_held_a;
                n_wb     = r_held_b;
                n_case   = w_case;
                n_n      = msc_pkg::edge_count(w_case);
                n_k      = '0;
                n_held_a = w_rpoint;
                n_held_b = r_cur;
                if (32'(w_row_inc) >= 32'(w_len_eff)) begin
                    n_row  = '0;
                    n_past = 1'b1;
                end else begin
                    n_row = w_row_inc[ROW_W-1:0];
                end
            end
            msc_pkg::ST_EDGE: begin
                n_e1    = w_p1;
                n_e2    = w_p2;
                n_coord = '0;
                n_mu    = '0;
                if (w_above) begin
                    n_e1 = (w_p1.v < w_p2.v) ? w_p1 : w_p2;
                end else if (w_below) begin
                    n_e1 = (w_p1.v > w_p2.v) ? w_p1 : w_p2;
                end
                if (w_above || w_below) begin
                    n_ox = n_e1.x;
                    n_oy = n_e1.y;
                    n_oz = n_e1.z;
                    n_oc = n_e1.c;
                end
            end
            msc_pkg::ST_DIV: begin
                if (w_div_done) n_mu = w_quo;
            end
            msc_pkg::ST_MUL: begin
                n_prod = $signed({1'b0, r_mu}) * w_dq;
            end
            msc_pkg::ST_ADD: begin
                case (r_coord)
                    2'd0:    n_ox = w_sum;
                    2'd1:    n_oy = w_sum;
                    2'd2:    n_oz = w_sum;
                    default: n_oc = r_col_en ? w_sum : r_e1.c;
                endcase
                n_coord = r_coord + 1'b1;
            end
            msc_pkg::ST_EMIT: begin
                if (w_emit_take) n_k = r_k + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= msc_pkg::ST_IDLE;
            r_row    <= '0;
            r_past   <= 1'b0;
            r_held_a <= '0;
            r_held_b <= '0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_past   <= n_past;
            r_held_a <= n_held_a;
            r_held_b <= n_held_b;
        end
        r_cur   <= n_cur;
        r_pc    <= n_pc;
        r_wa    <= n_wa;
        r_wb    <= n_wb;
        r_e1    <= n_e1;
        r_e2    <= n_e2;
        r_case  <= n_case;
        r_n     <= n_n;
        r_k     <= n_k;
        r_coord <= n_coord;
        r_mu    <= n_mu;
        r_prod  <= n_prod;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_oz    <= n_oz;
        r_oc    <= n_oc;
    end

    // outputs
    always_comb begin
        o_in_stall     = (r_state != msc_pkg::ST_IDLE);
        o_out_valid    = (r_state == msc_pkg::ST_EMIT);
        o_vert_x       = r_ox;
        o_vert_y       = r_oy;
        o_vert_z       = r_oz;
        o_vert_colour  = r_oc;
        o_cell_case    = r_case;
        o_last_of_cell = (3'(r_k) + 3'd1 == r_n);
    end

    // a vertex word is never offered while a new point can be taken
    a_no_out_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("vertex offered while input ready");

    // vertices only come from cells that cross the level
    a_case_crosses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cell_case != 4'd0) && (o_cell_case != 4'd15))
        else $error("vertex from a cell with no crossing");

    // divider completion always hands over to the multiplier
    a_div_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msc_pkg::ST_DIV) && w_div_done |=> (r_state == msc_pkg::ST_MUL))
        else $error("divider result lost");

    // a point with crossings produces at least one vertex slot
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msc_pkg::ST_EDGE) |-> (r_n != 3'd0) && (3'(r_k) < r_n))
        else $error("edge index beyond crossing count");

endmodule
`default_nettype wire

// ----- src/msc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module msc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- src/msc_div.sv -----
// Restoring divider for the interpolation fraction: one quotient bit a cycle.
// Uses msc_pkg widths. Requires numerator <= denominator, so mu <= 65536.
`default_nettype none
module msc_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [msc_pkg::DIV_W-1:0] i_num,
    input  wire logic [msc_pkg::DIV_W-1:0] i_den,
    output logic                           o_done,
    output logic      [msc_pkg::MU_W-1:0]  o_quo
);

    localparam int REM_W = msc_pkg::DIV_W + 1;
    localparam int CNT_W = $clog2(msc_pkg::MU_W + 1);

    logic [REM_W-1:0]           r_rem, n_rem;
    logic [msc_pkg::DIV_W-1:0]  r_den, n_den;
    logic [msc_pkg::MU_W-1:0]   r_quo, n_quo;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic                       r_done, n_done;
    logic                       w_ge;
    logic [REM_W-1:0]           w_diff;

    // one compare and subtract per step, then shift the remainder
    always_comb begin
        w_ge   = r_rem >= {1'b0, r_den};
        w_diff = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_rem = {1'b0, i_num};
            n_den = i_den;
            n_quo = '0;
            n_cnt = CNT_W'(msc_pkg::MU_W);
        end else if (r_cnt != '0) begin
            n_rem  = {w_diff[REM_W-2:0], 1'b0};
            n_quo  = {r_quo[msc_pkg::MU_W-2:0], w_ge};
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

// ----- bench/marching_squares_contour_test.sv -----
// Testbench for marching_squares_contour: streams grid points, predicts every
// contour vertex in-bench and checks each vertex word. Depends on msc_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none
module marching_squares_contour_test;

    localparam int EXP_DEPTH = 64;

    typedef struct {
        logic [31:0] x, y, z, c;
        logic [3:0]  cs;
        logic        last;
    } t_vertex;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_sample_value, i_pos_x, i_pos_y, i_pos_z, i_colour_value;
    logic        i_first_point;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_vert_x, o_vert_y, o_vert_z, o_vert_colour;
    logic [3:0]  o_cell_case;
    logic        o_last_of_cell;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    marching_squares_contour u_top (.*);

    // predictor state
    logic signed [31:0] iso_q;
    logic [10:0]        len_q;
    logic               colour_on;
    msc_pkg::t_point    col_buf [msc_pkg::MAX_COLUMN];
    msc_pkg::t_point    corner_a, prev_pt;
    int unsigned        row_idx;
    bit                 second_col;

    // expected vertex ring
    t_vertex     exp_buf [EXP_DEPTH];
    int unsigned exp_wr, exp_rd;
    int          mismatches;
    bit          quiet;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned pending_count();
        return exp_wr - exp_rd;
    endfunction

    function automatic logic [31:0] lerp_q(logic signed [31:0] p1, logic signed [31:0] p2,
                                           longint mu);
        longint prod;
        prod = mu * (longint'(p2) - longint'(p1));
        return 32'(longint'(p1) + (prod >>> 16));
    endfunction

    function automatic msc_pkg::t_point edge_point(msc_pkg::t_point a, msc_pkg::t_point b);
        msc_pkg::t_point r;
        longint num, den, mu;
        if (a.v > iso_q && b.v > iso_q) return (a.v < b.v) ? a : b;
        if (a.v < iso_q && b.v < iso_q) return (a.v > b.v) ? a : b;
        num = longint'(iso_q) - longint'(a.v);
        den = longint'(b.v) - longint'(a.v);
        mu = 0;
        if (den != 0) begin
            if (num < 0) num = -num;
            if (den < 0) den = -den;
            mu = (num << 16) / den;
        end
        r = a;
        r.x = lerp_q(a.x, b.x, mu);
        r.y = lerp_q(a.y, b.y, mu);
        r.z = lerp_q(a.z, b.z, mu);
        if (colour_on) r.c = lerp_q(a.c, b.c, mu);
        return r;
    endfunction

    // advance the predictor by one accepted point, queueing its vertices
    task automatic predict_vertices(msc_pkg::t_point cur, logic first);
        int unsigned len, j, n;
        msc_pkg::t_point pc, e1, e2, vx;
        logic [3:0] cs;
        msc_pkg::t_edge ed;
        t_vertex v;
        if (first) begin
            row_idx = 0;
            second_col = 0;
        end
        len = len_q;
        if (len < 1) len = 1;
        if (len > msc_pkg::MAX_COLUMN) len = msc_pkg::MAX_COLUMN;
        j = row_idx % msc_pkg::MAX_COLUMN;
        pc = col_buf[j];
        if (second_col && j >= 1) begin
            cs = {cur.v > iso_q, pc.v > iso_q, prev_pt.v > iso_q, corner_a.v > iso_q};
            n = (cs == 0 || cs == 15) ? 0 : ((cs == 6 || cs == 9) ? 4 : 2);
            for (int k = 0; k < n; k++) begin
                // edge order per case, built from the case table
                case (cs)
                    4'd1, 4'd14: ed = (k == 0) ? msc_pkg::EDGE_LEFT : msc_pkg::EDGE_BOTTOM;
                    4'd2, 4'd13: ed = (k == 0) ? msc_pkg::EDGE_RIGHT : msc_pkg::EDGE_BOTTOM;
                    4'd3, 4'd12: ed = (k == 0) ? msc_pkg::EDGE_LEFT : msc_pkg::EDGE_RIGHT;
                    4'd4:        ed = (k == 0) ? msc_pkg::EDGE_LEFT : msc_pkg::EDGE_TOP;
                    4'd5, 4'd10: ed = (k == 0) ? msc_pkg::EDGE_TOP : msc_pkg::EDGE_BOTTOM;
                    4'd6: ed = (k == 0) ? msc_pkg::EDGE_LEFT : (k == 1) ? msc_pkg::EDGE_TOP :
                               (k == 2) ? msc_pkg::EDGE_RIGHT : msc_pkg::EDGE_BOTTOM;
                    4'd7, 4'd8:  ed = (k == 0) ? msc_pkg::EDGE_TOP : msc_pkg::EDGE_RIGHT;
                    4'd9: ed = (k == 0) ? msc_pkg::EDGE_TOP : (k == 1) ? msc_pkg::EDGE_RIGHT :
                               (k == 2) ? msc_pkg::EDGE_BOTTOM : msc_pkg::EDGE_LEFT;
                    default:     ed = (k == 0) ? msc_pkg::EDGE_TOP : msc_pkg::EDGE_LEFT;
                endcase
                case (ed)
                    msc_pkg::EDGE_LEFT:   begin e1 = corner_a; e2 = pc;  end
                    msc_pkg::EDGE_RIGHT:  begin e1 = prev_pt;  e2 = cur; end
                    msc_pkg::EDGE_BOTTOM: begin e1 = corner_a; e2 = prev_pt; end
                    default:              begin e1 = pc;       e2 = cur; end
                endcase
                vx = edge_point(e1, e2);
                v.x = vx.x; v.y = vx.y; v.z = vx.z; v.c = vx.c;
                v.cs = cs;
                v.last = (k + 1 == n);
                exp_buf[exp_wr % EXP_DEPTH] = v;
                exp_wr++;
            end
        end
        corner_a = pc;
        prev_pt = cur;
        col_buf[j] = cur;
        row_idx = j + 1;
        if (row_idx >= len) begin
            row_idx = 0;
            second_col = 1;
        end
    endtask

    // send one grid point; returns after it is accepted
    task automatic send_point(msc_pkg::t_point p, logic first);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_sample_value = p.v; i_pos_x = p.x; i_pos_y = p.y; i_pos_z = p.z;
        i_colour_value = p.c; i_first_point = first;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        predict_vertices(p, first);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_count() != 0) @(negedge i_clk);
        // points with no vertex may still be in work
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            msc_pkg::CFG_ISO_LEVEL:     iso_q = data;
            msc_pkg::CFG_COLUMN_LENGTH: len_q = data[10:0];
            msc_pkg::CFG_COLOUR_ENABLE: colour_on = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(logic [31:0] iso, logic [31:0] len, logic col);
        drain();
        write_reg(msc_pkg::CFG_ISO_LEVEL, iso);
        write_reg(msc_pkg::CFG_COLUMN_LENGTH, len);
        write_reg(msc_pkg::CFG_COLOUR_ENABLE, {31'd0, col});
    endtask

    // value within a small window around the contour level
    function automatic logic [31:0] near_iso();
        longint t;
        t = longint'(iso_q) + longint'($urandom_range(0, 1 << 19)) - (1 << 18);
        if ($urandom_range(0, 7) == 0) t = iso_q;
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        return 32'(t);
    endfunction

    function automatic msc_pkg::t_point rand_point(logic [31:0] val);
        msc_pkg::t_point p;
        p.v = val; p.x = $urandom; p.y = $urandom; p.z = $urandom; p.c = $urandom;
        return p;
    endfunction

    // every case code once: column pairs walk a de Bruijn sequence
    task automatic test_all_cases();
        int unsigned seq[17] = '{0, 0, 1, 0, 2, 0, 3, 1, 1, 2, 1, 3, 2, 2, 3, 3, 0};
        logic [31:0] above, below;
        set_config(32'd0, 32'd2, 1'b1);
        for (int i = 0; i < 17; i++) begin
            for (int r = 0; r < 2; r++) begin
                above = $urandom_range(1, 1 << 20);
                below = ($urandom_range(0, 3) == 0) ? 32'd0 : -$urandom_range(1, 1 << 20);
                send_point(rand_point(seq[i][r] ? above : below), i == 0 && r == 0);
            end
        end
    endtask

    // level and field extremes; zero and minimum column lengths
    task automatic test_extremes();
        logic [31:0] vals[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
        msc_pkg::t_point p;
        set_config(32'h8000_0000, 32'd2, 1'b0);
        for (int i = 0; i < 8; i++) begin
            p.v = vals[i % 4];
            p.x = (i & 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            p.y = (i & 2) ? 32'h7fff_ffff : 32'h8000_0000;
            p.z = (i & 1) ? 32'hffff_ffff : 32'h0;
            p.c = (i & 4) ? 32'h8000_0000 : 32'h7fff_ffff;
            send_point(p, i == 0);
        end
        set_config(32'h7fff_ffff, 32'd0, 1'b1);
        for (int i = 0; i < 4; i++) send_point(rand_point(vals[i]), i == 0);
        set_config(32'h7ffffffe, 32'd1, 1'b1);
        for (int i = 0; i < 4; i++) send_point(rand_point(vals[i]), i == 0);
    endtask

    // long column: one full column and the first few points of the next
    task automatic test_long_column();
        set_config($urandom, 32'd200, 1'b1);
        for (int i = 0; i < 200 + 6; i++) begin
            send_point(rand_point(near_iso()), i == 0);
        end
    endtask

    // random grids, mostly near the level, with noise and stray restarts
    task automatic test_random_grids();
        int unsigned lens[6] = '{2, 3, 4, 5, 8, 3};
        msc_pkg::t_point p;
        for (int ph = 0; ph < 10; ph++) begin
            quiet = (ph >= 8);
            set_config(($urandom_range(0, 2) == 0) ? 32'd0 : $urandom,
                       lens[$urandom_range(0, 5)], 1'($urandom_range(0, 1)));
            for (int i = 0; i < 20; i++) begin
                p = rand_point(($urandom_range(0, 9) == 0) ? $urandom : near_iso());
                send_point(p, i == 0 || $urandom_range(0, 30) == 0);
                // let the block run dry once mid-grid
                if (ph == 2 && i == 10) begin
                    @(negedge i_clk);
                    i_in_valid = 1'b0;
                    while (pending_count() != 0) @(negedge i_clk);
                end
            end
        end
    endtask

    // receiver stall bursts
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 4) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 4) - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            i_out_stall = 1'b0;
        end
    end

    // vertex checker
    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_count() == 0) begin
                $display("%0t: unexpected vertex x=%h y=%h z=%h c=%h case=%0d last=%b", $time,
                         o_vert_x, o_vert_y, o_vert_z, o_vert_colour, o_cell_case,
                         o_last_of_cell);
                mismatches++;
            end else begin
                e = exp_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (e.x !== o_vert_x || e.y !== o_vert_y || e.z !== o_vert_z ||
                    e.c !== o_vert_colour || e.cs !== o_cell_case ||
                    e.last !== o_last_of_cell) begin
                    $display("%0t: expected x=%h y=%h z=%h c=%h case=%0d last=%b", $time,
                             e.x, e.y, e.z, e.c, e.cs, e.last);
                    $display("%0t: actual   x=%h y=%h z=%h c=%h case=%0d last=%b", $time,
                             o_vert_x, o_vert_y, o_vert_z, o_vert_colour, o_cell_case,
                             o_last_of_cell);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        mismatches = 0;
        quiet = 0;
        exp_wr = 0; exp_rd = 0;
        iso_q = 0; len_q = 11'd1; colour_on = 1'b0;
        corner_a = '0; prev_pt = '0; row_idx = 0; second_col = 0;
        foreach (col_buf[k]) col_buf[k] = '0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_sample_value = '0; i_pos_x = '0; i_pos_y = '0; i_pos_z = '0;
        i_colour_value = '0; i_first_point = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = msc_pkg::CFG_ISO_LEVEL; i_cfg_data = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_all_cases();
        test_extremes();
        test_long_column();
        test_random_grids();
        drain();
        if (pending_count() == 0 && mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
